### rtl/core/gbs_pkg.sv
// gbs_pkg: shared types and constants for the greedy box suppression block
// holds the box record, the comparison result record and sizing constants
// no dependencies
package gbs_pkg;

   localparam int          KeptDepthDefault = 128;
   localparam logic [7:0]  TopLimit         = 8'd128;
   localparam logic [7:0]  CountMax         = 8'd255;
   localparam logic [8:0]  ThreshReset      = 9'd77;
   localparam int          CoordWidth       = 12;
   localparam int          AreaWidth        = 2 * CoordWidth;

   typedef struct packed {
      logic [CoordWidth-1:0] box_left;
      logic [CoordWidth-1:0] box_top;
      logic [CoordWidth-1:0] box_width;
      logic [CoordWidth-1:0] box_height;
   } box_type;

   typedef struct packed {
      logic valid;
      logic suppress;
   } cmp_result_type;

endpackage

### rtl/core/gbs_kept_mem.sv
// gbs_kept_mem: synchronous store of the kept boxes of the current frame
// one write port, one read port with registered read data
// depends on gbs_pkg
module gbs_kept_mem
   import gbs_pkg::*;
#(
   parameter int KEPT_DEPTH = KeptDepthDefault,
   localparam int AddrWidth = $clog2(KEPT_DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AddrWidth-1:0] wr_addr,
   input  box_type              wr_data,
   input  logic                 rd_en,
   input  logic [AddrWidth-1:0] rd_addr,
   output box_type              rd_data
);

   box_type mem_array [KEPT_DEPTH];
   box_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_array[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_array[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/gbs_iou_pipe.sv
// gbs_iou_pipe: pipelined overlap test of the current box against one kept box per cycle
// five register stages: spans and both areas, intersection, union, scaled product, compare
// depends on gbs_pkg
module gbs_iou_pipe
   import gbs_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic [8:0]     threshold,
   input  box_type        cur_box,
   input  logic           kept_valid,
   input  box_type        kept_box,
   output cmp_result_type result
);

   function automatic logic [CoordWidth-1:0] span_len(
      input logic [CoordWidth-1:0] a0,
      input logic [CoordWidth-1:0] alen,
      input logic [CoordWidth-1:0] b0,
      input logic [CoordWidth-1:0] blen
   );
      logic signed [CoordWidth+1:0] sa0;
      logic signed [CoordWidth+1:0] sa1;
      logic signed [CoordWidth+1:0] sb0;
      logic signed [CoordWidth+1:0] sb1;
      logic signed [CoordWidth+1:0] lo;
      logic signed [CoordWidth+1:0] hi;
      logic signed [CoordWidth+1:0] diff;
      sa0  = {{2{a0[CoordWidth-1]}}, a0};
      sb0  = {{2{b0[CoordWidth-1]}}, b0};
      sa1  = sa0 + $signed({2'b00, alen});
      sb1  = sb0 + $signed({2'b00, blen});
      lo   = (sa0 > sb0) ? sa0 : sb0;
      hi   = (sa1 < sb1) ? sa1 : sb1;
      diff = hi - lo;
      span_len = (hi > lo) ? diff[CoordWidth-1:0] : '0;
   endfunction

   logic [4:0]             valid_ff;
   logic [AreaWidth-1:0]   area_a_ff;
   logic [CoordWidth-1:0]  iw_ff;
   logic [CoordWidth-1:0]  ih_ff;
   logic [AreaWidth-1:0]   area_b1_ff;
   logic [AreaWidth-1:0]   area_b2_ff;
   logic [AreaWidth-1:0]   inter2_ff;
   logic [AreaWidth-1:0]   inter3_ff;
   logic [AreaWidth:0]     union3_ff;
   logic [AreaWidth+9:0]   prod4_ff;
   logic [AreaWidth+9:0]   scaled4_ff;
   logic                   zero4_ff;
   logic                   suppress_ff;
   logic [AreaWidth:0]     union_in;
   logic [AreaWidth+9:0]   prod_in;

   assign union_in = {1'b0, area_a_ff} + {1'b0, area_b2_ff} - {1'b0, inter2_ff};
   assign prod_in  = {{(AreaWidth+1){1'b0}}, threshold} * {9'b0, union3_ff};

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[3:0], kept_valid};
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      area_a_ff   <= cur_box.box_width * cur_box.box_height;
      iw_ff       <= span_len(cur_box.box_left, cur_box.box_width,
                              kept_box.box_left, kept_box.box_width);
      ih_ff       <= span_len(cur_box.box_top, cur_box.box_height,
                              kept_box.box_top, kept_box.box_height);
      area_b1_ff  <= kept_box.box_width * kept_box.box_height;
      inter2_ff   <= iw_ff * ih_ff;
      area_b2_ff  <= area_b1_ff;
      union3_ff   <= union_in;
      inter3_ff   <= inter2_ff;
      prod4_ff    <= prod_in;
      scaled4_ff  <= {2'b00, inter3_ff, 8'b0};
      zero4_ff    <= (union3_ff == '0);
      suppress_ff <= zero4_ff || (scaled4_ff > prod4_ff);
   end

   assign result.valid    = valid_ff[4];
   assign result.suppress = suppress_ff;

endmodule

### rtl/core/greedy_box_suppression.sv
// greedy_box_suppression: greedy non-maximum suppression of score-ordered boxes
// sequencer, counters, threshold register and result register around the kept store
// depends on gbs_pkg, gbs_kept_mem, gbs_iou_pipe
//
//   port group   direction   handshake          payload
//   req_         in          valid / stall      first_of_frame, box geometry
//   rsp_         out         valid / stall      keep, over_limit, box_number
//   csr_         in          valid / ready      overlap threshold, 9 bits
//
// a box reads one entry of the kept store per cycle into the five-stage
// overlap pipeline, which is then drained
// a box past the top-k limit, or one with an empty kept list, skips the scan
// reset clears the counters and sets the threshold to 77; the store is not cleared
// a new box is taken while the previous result is still held; a stalled result
// holds the sequencer in its final state
module greedy_box_suppression
   import gbs_pkg::*;
#(
   parameter int KEPT_DEPTH = KeptDepthDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_first_of_frame,
   input  logic [CoordWidth-1:0] req_box_left,
   input  logic [CoordWidth-1:0] req_box_top,
   input  logic [CoordWidth-1:0] req_box_width,
   input  logic [CoordWidth-1:0] req_box_height,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_keep,
   output logic                  rsp_over_limit,
   output logic [7:0]            rsp_box_number,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [8:0]            csr_data
);

   localparam int AddrWidth = $clog2(KEPT_DEPTH);
   localparam int CntWidth  = $clog2(KEPT_DEPTH + 1);
   localparam logic [CntWidth-1:0] KeptFull = CntWidth'(KEPT_DEPTH);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic [8:0]            thresh_ff;
   logic [CntWidth-1:0]   kept_cnt_ff, kept_cnt_in;
   logic [7:0]            frame_cnt_ff, frame_cnt_in;
   logic [AddrWidth-1:0]  rd_idx_ff, rd_idx_in;
   logic [CntWidth-1:0]   res_cnt_ff, res_cnt_in;
   logic                  rd_valid_ff;
   logic                  supp_ff, supp_in;
   logic                  limit_ff, limit_in;
   logic [7:0]            number_ff, number_in;
   box_type               cur_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_keep_ff;
   logic                  rsp_over_ff;
   logic [7:0]            rsp_number_ff;

   logic                  req_xfer;
   logic                  rd_en;
   logic                  out_free;
   logic                  finish_go;
   logic                  survive;
   logic                  room;
   logic                  wr_en;
   box_type               req_box;
   box_type               kept_box;
   cmp_result_type        cmp_res;

   assign req_box.box_left   = req_box_left;
   assign req_box.box_top    = req_box_top;
   assign req_box.box_width  = req_box_width;
   assign req_box.box_height = req_box_height;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rd_en     = (state_ff == ST_SCAN);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign finish_go = (state_ff == ST_FINISH) && out_free;
   assign survive   = !limit_ff && !supp_ff;
   assign room      = (kept_cnt_ff < KeptFull);
   assign wr_en     = finish_go && survive && room;

   gbs_kept_mem #(
      .KEPT_DEPTH (KEPT_DEPTH)
   ) u_kept_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (kept_cnt_ff[AddrWidth-1:0]),
      .wr_data (cur_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff),
      .rd_data (kept_box)
   );

   gbs_iou_pipe u_iou_pipe (
      .clock      (clock),
      .reset      (reset),
      .threshold  (thresh_ff),
      .cur_box    (cur_ff),
      .kept_valid (rd_valid_ff),
      .kept_box   (kept_box),
      .result     (cmp_res)
   );

   always_comb begin
      state_in     = state_ff;
      kept_cnt_in  = kept_cnt_ff;
      frame_cnt_in = frame_cnt_ff;
      rd_idx_in    = rd_idx_ff;
      res_cnt_in   = res_cnt_ff;
      supp_in      = supp_ff;
      limit_in     = limit_ff;
      number_in    = number_ff;
      if (cmp_res.valid) begin
         res_cnt_in = res_cnt_ff + 1'b1;
         supp_in    = supp_ff | cmp_res.suppress;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               number_in    = req_first_of_frame ? 8'd0 : frame_cnt_ff;
               kept_cnt_in  = req_first_of_frame ? '0 : kept_cnt_ff;
               frame_cnt_in = (number_in < CountMax) ? number_in + 8'd1 : CountMax;
               limit_in     = (number_in >= TopLimit);
               supp_in      = 1'b0;
               rd_idx_in    = '0;
               res_cnt_in   = '0;
               if (limit_in || kept_cnt_in == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            rd_idx_in = rd_idx_ff + 1'b1;
            if (CntWidth'(rd_idx_ff) + 1'b1 == kept_cnt_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (res_cnt_ff == kept_cnt_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               if (wr_en) begin
                  kept_cnt_in = kept_cnt_ff + 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         thresh_ff    <= ThreshReset;
         kept_cnt_ff  <= '0;
         frame_cnt_ff <= '0;
         res_cnt_ff   <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kept_cnt_ff  <= kept_cnt_in;
         frame_cnt_ff <= frame_cnt_in;
         res_cnt_ff   <= res_cnt_in;
         rd_valid_ff  <= rd_en;
         if (csr_valid && csr_ready) begin
            thresh_ff <= csr_data;
         end
         if (finish_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      supp_ff   <= supp_in;
      limit_ff  <= limit_in;
      number_ff <= number_in;
      if (req_xfer) begin
         cur_ff <= req_box;
      end
      if (finish_go) begin
         rsp_keep_ff   <= survive && room;
         rsp_over_ff   <= limit_ff || (survive && !room);
         rsp_number_ff <= number_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_keep       = rsp_keep_ff;
   assign rsp_over_limit = rsp_over_ff;
   assign rsp_box_number = rsp_number_ff;

endmodule
